FILE: design/pss_pkg.sv
package pss_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = 4;
	localparam int TIME_W = 32;

	typedef enum logic [1:0] {
		ACT_SCAN   = 2'd0,
		ACT_RUNALL = 2'd1,
		ACT_SET    = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	typedef struct packed {
		logic start;
		logic [TIME_W-1:0] dividend;
		logic [TIME_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [TIME_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

FILE: design/periodic_slot_scheduler.sv
// periodic_slot_scheduler: table of 16 periodic task slots.
// Input items on s_axis: tuser carries the action (scan, run-all, set, read),
// tdata the times and slot settings. Results leave on m_axis; tlast marks the
// final result an input item causes. cfg_we/cfg_wdata load idle_wait.
// s_axis_tready is high only while the sequencer is idle: one item at a time.
// Set gives no result. Read gives one result. Run-all walks all 16 slots.
// Scan walks all 16 slots; a due slot with a nonzero period waits on the
// shared radix-2 divider, and each due slot uses the multiplier. The divider
// is the bound on throughput.
// Reset clears all slots to inactive with zero statistics and idle_wait to 1.
// A stall on m_axis holds the result in the output register; the sequencer
// waits until that register is free before writing the next result.
module periodic_slot_scheduler
	import pss_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// now, prior_wake, slot, active, period, first_run
	input  logic [135:0] s_axis_tdata,
	// action
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// task_slot, runs, overruns, prev_run, wake_time, wait_seconds
	output logic [167:0] m_axis_tdata,
	// task_valid
	output logic [0:0]   m_axis_tuser,
	output logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE, S_SLOT, S_DIV, S_MUL, S_UPD, S_RUNALL, S_SUM, S_READ
	} state_t;

	state_t            state_q;
	action_t           act_q;
	logic [SLOT_W-1:0] idx_q;
	logic [TIME_W-1:0] now_q, wake_q, missed_q, prod_q;
	logic [15:0]       idle_wait_q;

	logic [SLOTS-1:0]  active_q;
	logic [SLOTS-1:0]  wr_q;
	logic [TIME_W-1:0] period_q  [SLOTS];
	logic [TIME_W-1:0] next_q    [SLOTS];
	logic [TIME_W-1:0] runs_q    [SLOTS];
	logic [TIME_W-1:0] ovr_q     [SLOTS];
	logic [TIME_W-1:0] lastrun_q [SLOTS];

	logic              m_valid_q;
	logic [167:0]      m_data_q;
	logic              m_user_q;
	logic              m_last_q;

	div_req_t          dreq;
	div_rsp_t          drsp;

	logic [TIME_W-1:0] in_now, in_wake, in_period, in_first;
	logic [SLOT_W-1:0] in_slot;
	logic              in_active;
	logic              in_acc, out_free, idx_end, more_active, m_load;
	logic [TIME_W-1:0] cur_per, cur_next, cur_runs, cur_ovr, cur_lr;
	logic [TIME_W-1:0] new_runs, new_ovr, wait_val;

	assign in_now    = s_axis_tdata[31:0];
	assign in_wake   = s_axis_tdata[63:32];
	assign in_slot   = s_axis_tdata[67:64];
	assign in_active = s_axis_tdata[68];
	assign in_period = s_axis_tdata[100:69];
	assign in_first  = s_axis_tdata[132:101];

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign idx_end       = (idx_q == SLOT_W'(SLOTS - 1));
	assign m_load        = out_free && (state_q == S_UPD || state_q == S_RUNALL
		|| state_q == S_SUM || state_q == S_READ);

	always_comb begin
		cur_per  = period_q[idx_q];
		cur_next = next_q[idx_q];
		cur_runs = wr_q[idx_q] ? runs_q[idx_q] : '0;
		cur_ovr  = wr_q[idx_q] ? ovr_q[idx_q] : '0;
		cur_lr   = wr_q[idx_q] ? lastrun_q[idx_q] : '0;
		new_runs = sat_add(cur_runs, TIME_W'(1));
		new_ovr  = sat_add(cur_ovr, missed_q);
		more_active = 1'b0;
		for (int j = 0; j < SLOTS; j++) begin
			if (SLOT_W'(j) > idx_q && active_q[j])
				more_active = 1'b1;
		end
		if (wake_q == '0)
			wait_val = TIME_W'(idle_wait_q);
		else if (wake_q > now_q)
			wait_val = wake_q - now_q;
		else
			wait_val = '0;
	end

	assign dreq.start    = (state_q == S_SLOT) && (act_q == ACT_SCAN) && active_q[idx_q]
		&& (now_q >= cur_next) && (cur_per != '0);
	assign dreq.dividend = now_q - cur_next;
	assign dreq.divisor  = cur_per;

	pss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			act_q       <= ACT_SCAN;
			idx_q       <= '0;
			active_q    <= '0;
			wr_q        <= '0;
			idle_wait_q <= 16'd1;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_we)
				idle_wait_q <= cfg_wdata;
			if (m_load)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						act_q <= action_t'(s_axis_tuser);
						unique case (action_t'(s_axis_tuser))
							ACT_SET: begin
								active_q[in_slot] <= in_active;
								wr_q[in_slot]     <= 1'b1;
							end
							ACT_READ: begin
								idx_q   <= in_slot;
								state_q <= S_READ;
							end
							default: begin
								idx_q   <= '0;
								state_q <= S_SLOT;
							end
						endcase
					end
				end
				S_SLOT: begin
					if (!active_q[idx_q]) begin
						idx_q <= idx_q + 1'b1;
						if (idx_end)
							state_q <= (act_q == ACT_SCAN) ? S_SUM : S_IDLE;
					end else if (act_q == ACT_RUNALL) begin
						state_q <= S_RUNALL;
					end else if (now_q < cur_next) begin
						idx_q <= idx_q + 1'b1;
						if (idx_end)
							state_q <= S_SUM;
					end else if (cur_per == '0) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (drsp.done)
						state_q <= S_MUL;
				end
				S_MUL: state_q <= S_UPD;
				S_UPD, S_RUNALL: begin
					if (out_free) begin
						wr_q[idx_q] <= 1'b1;
						idx_q       <= idx_q + 1'b1;
						if (idx_end)
							state_q <= (act_q == ACT_SCAN) ? S_SUM : S_IDLE;
						else
							state_q <= S_SLOT;
					end
				end
				S_SUM, S_READ: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				now_q  <= in_now;
				wake_q <= in_wake;
				if (in_acc && action_t'(s_axis_tuser) == ACT_SET) begin
					period_q[in_slot]  <= in_period;
					next_q[in_slot]    <= in_first;
					runs_q[in_slot]    <= '0;
					ovr_q[in_slot]     <= '0;
					lastrun_q[in_slot] <= '0;
				end
			end
			S_SLOT: begin
				if (active_q[idx_q] && act_q == ACT_SCAN) begin
					if (wake_q == '0 || cur_next < wake_q)
						wake_q <= cur_next;
				end
				missed_q <= '0;
			end
			S_DIV: missed_q <= drsp.quotient;
			S_MUL: prod_q <= TIME_W'((missed_q + TIME_W'(1)) * cur_per);
			S_UPD: begin
				if (out_free) begin
					runs_q[idx_q]    <= new_runs;
					ovr_q[idx_q]     <= new_ovr;
					lastrun_q[idx_q] <= now_q;
					next_q[idx_q]    <= cur_next + prod_q;
					m_data_q <= {4'd0, 64'd0, now_q, new_ovr, new_runs, idx_q};
					m_user_q <= 1'b1;
					m_last_q <= 1'b0;
				end
			end
			S_RUNALL: begin
				if (out_free) begin
					runs_q[idx_q]    <= new_runs;
					ovr_q[idx_q]     <= cur_ovr;
					lastrun_q[idx_q] <= now_q;
					m_data_q <= {4'd0, 64'd0, now_q, cur_ovr, new_runs, idx_q};
					m_user_q <= 1'b1;
					m_last_q <= !more_active;
				end
			end
			S_SUM: begin
				if (out_free) begin
					m_data_q <= {4'd0, wait_val, wake_q, 96'd0, SLOT_W'(0)};
					m_user_q <= 1'b0;
					m_last_q <= 1'b1;
				end
			end
			S_READ: begin
				if (out_free) begin
					m_data_q <= {4'd0, 64'd0, cur_lr, cur_ovr, cur_runs, idx_q};
					m_user_q <= 1'b1;
					m_last_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = m_data_q;
	assign m_axis_tuser[0] = m_user_q;
	assign m_axis_tlast    = m_last_q;

endmodule

FILE: design/pss_div.sv
module pss_div
	import pss_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(TIME_W + 1);

	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] quo_q;
	logic [TIME_W-1:0] dsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [TIME_W:0]   rem_sh;
	logic [TIME_W:0]   diff;
	logic              ge;

	always_comb begin
		rem_sh = {rem_q, quo_q[TIME_W-1]};
		diff   = rem_sh - {1'b0, dsr_q};
		ge     = !diff[TIME_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(TIME_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
			quo_q <= {quo_q[TIME_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
